/* sv/knock_rhythm_detector_top_macros.svh */
// Assertion helpers used by the RTL file that carries checks.
`ifndef KNOCK_RHYTHM_DETECTOR_TOP_MACROS_SVH
`define KNOCK_RHYTHM_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define KRD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define KRD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/krd_pkg.sv */
package krd_pkg;

    // Time and register widths.
    localparam int TIME_BITS = 48;
    localparam int CFG_BITS = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int CNT_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_DETECT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SEP = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SEP = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUIET = 3'd4;

    // Configuration reset values.
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST = 24'd50000;
    localparam logic [CFG_BITS-1:0] MIN_SEP_RST = 24'd300000;
    localparam logic [CFG_BITS-1:0] MAX_SEP_RST = 24'd800000;
    localparam logic [CFG_BITS-1:0] QUIET_RST = 24'd1000000;

    // Request kinds.
    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Pulse classification codes.
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_DEBOUNCED = 2'd1;
    localparam logic [1:0] CLS_IGNORED = 2'd2;
    localparam logic [1:0] CLS_COUNTED = 2'd3;

    // Rhythm count milestones.
    localparam logic [CNT_BITS-1:0] CNT_FIRST = 3'd1;
    localparam logic [CNT_BITS-1:0] CNT_PERIOD = 3'd2;
    localparam logic [CNT_BITS-1:0] CNT_ARM = 3'd3;
    localparam logic [CNT_BITS-1:0] CNT_MAX = 3'd4;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic req_type;
        time_t now_us;
        logic y_negative;
    } krd_req_t;

    typedef struct packed {
        logic trigger;
        logic [1:0] pulse_class;
        logic [CNT_BITS-1:0] knock_count;
    } krd_rsp_t;

    typedef struct packed {
        logic detect_enable;
        logic [CFG_BITS-1:0] debounce_us;
        logic [CFG_BITS-1:0] min_separation_us;
        logic [CFG_BITS-1:0] max_separation_us;
        logic [CFG_BITS-1:0] quiet_us;
    } krd_cfg_t;

    // The knock window is either the default bounds captured from the
    // configuration, or 4/5 to 6/5 of a stored gap (compared without division).
    typedef struct packed {
        time_t last_knock_time;
        time_t last_pulse_time;
        logic win_from_gap;
        time_t win_gap;
        logic [CFG_BITS-1:0] win_low_def;
        logic [CFG_BITS-1:0] win_high_def;
        logic [CNT_BITS-1:0] beat_count;
        logic timer_armed;
        time_t timer_deadline;
    } krd_state_t;

endpackage

/* sv/krd_core.sv */
module krd_core (
    input  krd_pkg::krd_cfg_t   cfg,
    input  krd_pkg::krd_state_t state,
    input  krd_pkg::krd_req_t   req,
    output krd_pkg::krd_state_t state_next,
    output krd_pkg::krd_rsp_t   rsp
);
    import krd_pkg::*;

    localparam int EXT_BITS = TIME_BITS + 3;

    time_t now;
    logic expired;
    logic pulse_en;
    logic debounced;
    logic ahead;
    time_t gap;
    logic [EXT_BITS-1:0] gap_x5;
    logic [EXT_BITS-1:0] win_x4;
    logic [EXT_BITS-1:0] win_x6;
    logic below_win;
    logic above_win;
    logic off_window;
    logic restart;
    logic [CNT_BITS-1:0] cnt_base;
    logic [CNT_BITS-1:0] cnt_new;
    logic [TIME_BITS:0] deadline_sum;
    time_t deadline;

    assign now = req.now_us;

    // Quiet timer expiry is checked first on every request.
    assign expired = state.timer_armed && (now >= state.timer_deadline);

    assign pulse_en = (req.req_type == REQ_PULSE) && cfg.detect_enable;

    // A pulse earlier than the previous one also counts as a bounce.
    assign debounced = (now < state.last_pulse_time) ||
        ((now - state.last_pulse_time) < {{(TIME_BITS-CFG_BITS){1'b0}}, cfg.debounce_us});

    assign ahead = now >= state.last_knock_time;
    assign gap = ahead ? (now - state.last_knock_time) : '0;

    // gap < floor(4g/5) is 5*gap + 5 <= 4g; gap > floor(6g/5) is 5*gap > 6g.
    assign gap_x5 = {1'b0, gap, 2'b00} + {3'b000, gap};
    assign win_x4 = {1'b0, state.win_gap, 2'b00};
    assign win_x6 = {1'b0, state.win_gap, 2'b00} + {2'b00, state.win_gap, 1'b0};

    always_comb begin
        if (state.win_from_gap) begin
            below_win = (gap_x5 + EXT_BITS'(5)) <= win_x4;
            above_win = gap_x5 > win_x6;
        end else begin
            below_win = gap < {{(TIME_BITS-CFG_BITS){1'b0}}, state.win_low_def};
            above_win = gap > {{(TIME_BITS-CFG_BITS){1'b0}}, state.win_high_def};
        end
    end

    assign off_window = !ahead || below_win || above_win;

    // An off-window knock at count two may start over as a second knock.
    assign restart = (state.beat_count == CNT_PERIOD) && ahead &&
        (gap > {{(TIME_BITS-CFG_BITS){1'b0}}, cfg.min_separation_us}) &&
        (gap < {{(TIME_BITS-CFG_BITS){1'b0}}, cfg.max_separation_us});

    always_comb begin
        if (!off_window) begin
            cnt_base = state.beat_count;
        end else if (restart) begin
            cnt_base = CNT_FIRST;
        end else begin
            cnt_base = '0;
        end
        cnt_new = (cnt_base < CNT_MAX) ? (cnt_base + CNT_BITS'(1)) : cnt_base;
    end

    // Deadline saturates at the largest time value.
    assign deadline_sum = {1'b0, now} + {{(TIME_BITS+1-CFG_BITS){1'b0}}, cfg.quiet_us};
    assign deadline = deadline_sum[TIME_BITS] ? '1 : deadline_sum[TIME_BITS-1:0];

    // Next state and response.
    always_comb begin
        state_next = state;
        rsp.trigger = expired;
        rsp.pulse_class = CLS_NONE;
        if (expired) begin
            state_next.timer_armed = 1'b0;
        end
        if (pulse_en) begin
            state_next.last_pulse_time = now;
            if (debounced) begin
                rsp.pulse_class = CLS_DEBOUNCED;
            end else if (req.y_negative) begin
                rsp.pulse_class = CLS_IGNORED;
            end else begin
                rsp.pulse_class = CLS_COUNTED;
                state_next.last_knock_time = now;
                if (off_window) begin
                    state_next.timer_armed = 1'b0;
                    if (!restart) begin
                        state_next.win_from_gap = 1'b0;
                        state_next.win_low_def = cfg.min_separation_us;
                        state_next.win_high_def = cfg.max_separation_us;
                    end
                end
                state_next.beat_count = cnt_new;
                case (cnt_new)
                    CNT_PERIOD: begin
                        state_next.win_from_gap = 1'b1;
                        state_next.win_gap = gap;
                    end
                    CNT_ARM: begin
                        state_next.timer_armed = 1'b1;
                        state_next.timer_deadline = deadline;
                    end
                    CNT_MAX: begin
                        state_next.timer_armed = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        rsp.knock_count = state_next.beat_count;
    end

endmodule

/* sv/knock_rhythm_detector_top.sv */
// Knock rhythm detector.
// Requests enter on s_valid/s_ready/s_data: a tap pulse with its time stamp
// and axis flag, or a plain time tick. Each request yields exactly one result
// on m_valid/m_ready/m_data: the trigger flag, the pulse class and the rhythm
// count after the request. Time stamps normally do not decrease; an earlier
// stamp is handled as a bounce or an off-beat knock.
// The path is one input register, one pass through the step logic and one
// result register. One request per cycle is sustained while m_ready stays
// high; the rhythm state is updated in the same cycle a request moves into the
// result register, so the next request sees it.
// When the receiver stalls, the result register holds its request and the
// input register takes one more request; s_ready then drops until the result
// is taken. Configuration is written through cfg_we/cfg_addr/cfg_wdata; the
// user must write it only while the block is idle, which the block does not
// enforce. Writes to unused indexes are ignored. A synchronous low aresetn
// empties both registers, clears the rhythm state and returns the configuration to its default values.
module knock_rhythm_detector_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  krd_pkg::krd_req_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output krd_pkg::krd_rsp_t                    m_data,
    input  logic                                 cfg_we,
    input  logic [krd_pkg::CFG_IDX_BITS-1:0]     cfg_addr,
    input  logic [krd_pkg::CFG_BITS-1:0]         cfg_wdata
);
    import krd_pkg::*;

`include "knock_rhythm_detector_top_macros.svh"

    krd_cfg_t cfg_reg;
    krd_cfg_t cfg_next;
    krd_state_t state_reg;
    krd_state_t state_next;
    krd_req_t in_data_reg;
    logic in_valid_reg;
    logic in_valid_next;
    krd_rsp_t out_data_reg;
    krd_rsp_t rsp;
    logic out_valid_reg;
    logic out_valid_next;
    logic s_accept;
    logic advance;

    // Handshake: the input register moves on whenever the result slot frees up.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data = out_data_reg;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_DETECT_ENABLE: cfg_next.detect_enable = cfg_wdata[0];
                CFG_DEBOUNCE:      cfg_next.debounce_us = cfg_wdata;
                CFG_MIN_SEP:       cfg_next.min_separation_us = cfg_wdata;
                CFG_MAX_SEP:       cfg_next.max_separation_us = cfg_wdata;
                CFG_QUIET:         cfg_next.quiet_us = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Step logic for the request held in the input register.
    krd_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .req        (in_data_reg),
        .state_next (state_next),
        .rsp        (rsp)
    );

    // Valid flags of the two registers.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control, configuration and rhythm state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.detect_enable <= 1'b0;
            cfg_reg.debounce_us <= DEBOUNCE_RST;
            cfg_reg.min_separation_us <= MIN_SEP_RST;
            cfg_reg.max_separation_us <= MAX_SEP_RST;
            cfg_reg.quiet_us <= QUIET_RST;
            state_reg.last_knock_time <= '0;
            state_reg.last_pulse_time <= '0;
            state_reg.win_from_gap <= 1'b0;
            state_reg.win_gap <= '0;
            state_reg.win_low_def <= MIN_SEP_RST;
            state_reg.win_high_def <= MAX_SEP_RST;
            state_reg.beat_count <= '0;
            state_reg.timer_armed <= 1'b0;
            state_reg.timer_deadline <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg <= cfg_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= rsp;
        end
    end

    // The quiet timer runs only after the third knock of a rhythm.
    `KRD_ASSERT_NOW(a_armed_at_three, aclk, aresetn, state_reg.timer_armed,
                    state_reg.beat_count == CNT_ARM, "timer armed outside count three")
    // A waiting result always reflects the latest rhythm state.
    `KRD_ASSERT_NOW(a_count_matches, aclk, aresetn, m_valid,
                    m_data.knock_count == state_reg.beat_count, "result count differs from state")
    // A stall of the input side only happens when both stages are full.
    `KRD_ASSERT_NEXT(a_stall_full, aclk, aresetn, s_valid && !s_ready,
                     in_valid_reg || out_valid_reg, "input stalled with empty stages")

endmodule

/* verif/knock_rhythm_detector_top_tb.sv */
module knock_rhythm_detector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import krd_pkg::*;

    localparam time_t TIME_MAX = '1;
    localparam logic [CFG_BITS-1:0] CFG_MAX_VAL = '1;
    localparam int unsigned CFG_MAX_U = 32'(CFG_MAX_VAL);
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = '1;
    localparam int RANDOM_ITEMS = 1050;
    localparam int PHASE_ITEMS = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 300;

    // Block ports, all inputs known from time zero.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    krd_req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    krd_rsp_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_addr = '0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;

    // Predicted configuration, starting from the reset values.
    logic en_cfg = 1'b0;
    logic [CFG_BITS-1:0] debounce_cfg = DEBOUNCE_RST;
    logic [CFG_BITS-1:0] min_sep_cfg = MIN_SEP_RST;
    logic [CFG_BITS-1:0] max_sep_cfg = MAX_SEP_RST;
    logic [CFG_BITS-1:0] quiet_cfg = QUIET_RST;

    // Predicted rhythm state.
    time_t last_knock_q = '0;
    time_t last_pulse_q = '0;
    time_t win_lo_q = time_t'(MIN_SEP_RST);
    time_t win_hi_q = time_t'(MAX_SEP_RST);
    logic [CNT_BITS-1:0] count_q = '0;
    logic armed_q = 1'b0;
    time_t deadline_q = '0;

    krd_rsp_t predicted_rsp_q[$];
    int mismatch_count = 0;
    int unsigned sent_count = 0;
    bit calm = 1'b0;
    bit hold_off_req = 1'b0;
    time_t clock_us = '0;

    knock_rhythm_detector_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Advances the predicted rhythm by one request and returns its result.
    function automatic krd_rsp_t advance_rhythm(krd_req_t req);
        krd_rsp_t rsp;
        time_t now;
        time_t gap;
        logic ahead;
        logic [63:0] lo_wide;
        logic [63:0] hi_wide;
        logic [63:0] due_wide;
        rsp = '0;
        now = req.now_us;
        // The quiet timer expires on any request, enabled or not.
        if (armed_q && now >= deadline_q) begin
            rsp.trigger = 1'b1;
            armed_q = 1'b0;
        end
        if (req.req_type == REQ_PULSE && en_cfg) begin
            if (now < last_pulse_q || (now - last_pulse_q) < time_t'(debounce_cfg)) begin
                rsp.pulse_class = CLS_DEBOUNCED;
                last_pulse_q = now;
            end else if (req.y_negative) begin
                rsp.pulse_class = CLS_IGNORED;
                last_pulse_q = now;
            end else begin
                ahead = (now >= last_knock_q);
                gap = ahead ? now - last_knock_q : '0;
                rsp.pulse_class = CLS_COUNTED;
                // An off-beat knock restarts as a second knock or drops the rhythm.
                if (!ahead || gap < win_lo_q || gap > win_hi_q) begin
                    armed_q = 1'b0;
                    if (count_q == CNT_PERIOD && ahead && gap > time_t'(min_sep_cfg)
                            && gap < time_t'(max_sep_cfg)) begin
                        count_q = CNT_FIRST;
                    end else begin
                        win_lo_q = time_t'(min_sep_cfg);
                        win_hi_q = time_t'(max_sep_cfg);
                        count_q = '0;
                    end
                end
                if (count_q < CNT_MAX) begin
                    count_q++;
                end
                if (count_q == CNT_PERIOD) begin
                    lo_wide = (64'(gap) * 64'd4) / 64'd5;
                    hi_wide = (64'(gap) * 64'd6) / 64'd5;
                    win_lo_q = lo_wide[TIME_BITS-1:0];
                    win_hi_q = (hi_wide > 64'(TIME_MAX)) ? TIME_MAX : hi_wide[TIME_BITS-1:0];
                end else if (count_q == CNT_ARM) begin
                    armed_q = 1'b1;
                    due_wide = 64'(now) + 64'(quiet_cfg);
                    deadline_q = (due_wide > 64'(TIME_MAX)) ? TIME_MAX
                                                            : due_wide[TIME_BITS-1:0];
                end else if (count_q >= CNT_MAX) begin
                    armed_q = 1'b0;
                end
                last_knock_q = now;
                last_pulse_q = now;
            end
        end
        rsp.knock_count = count_q;
        return rsp;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_cfg(int unsigned lo, int unsigned hi);
        return CFG_BITS'($urandom_range(hi, lo));
    endfunction

    // Knock period, usually inside the configured spacing bounds.
    function automatic int unsigned pick_period();
        int unsigned lo;
        int unsigned hi;
        lo = (min_sep_cfg < max_sep_cfg) ? 32'(min_sep_cfg) : 32'(max_sep_cfg);
        hi = (min_sep_cfg < max_sep_cfg) ? 32'(max_sep_cfg) : 32'(min_sep_cfg);
        if ($urandom_range(9) == 0) return $urandom_range(CFG_MAX_U, 1);
        return $urandom_range(hi, lo);
    endfunction

    function automatic void compare_field(string name, logic [2:0] want, logic [2:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offers one request and records its predicted result once it is taken.
    task automatic send_req(input logic kind, input time_t stamp, input logic neg_y);
        krd_req_t req;
        int idle;
        req.req_type = kind;
        req.now_us = stamp;
        req.y_negative = neg_y;
        idle = calm ? 0 : pick_idle();
        if (idle > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (idle - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted_rsp_q.push_back(advance_rhythm(req));
        sent_count++;
    endtask

    // Stops offering requests until every predicted result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (predicted_rsp_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DETECT_ENABLE: en_cfg = value[0];
            CFG_DEBOUNCE:      debounce_cfg = value;
            CFG_MIN_SEP:       min_sep_cfg = value;
            CFG_MAX_SEP:       max_sep_cfg = value;
            CFG_QUIET:         quiet_cfg = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_BITS-1:0] enable_word, debounce, min_sep,
                              max_sep, quiet);
        write_reg(CFG_DETECT_ENABLE, enable_word);
        write_reg(CFG_DEBOUNCE, debounce);
        write_reg(CFG_MIN_SEP, min_sep);
        write_reg(CFG_MAX_SEP, max_sep);
        write_reg(CFG_QUIET, quiet);
    endtask

    // One knock sequence with random content, stray pulses and a quiet tail.
    task automatic play_rhythm();
        time_t t;
        int unsigned period;
        int unsigned jit;
        int unsigned knocks;
        calm = ($urandom_range(5) == 0);
        if ($urandom_range(24) == 0) begin
            clock_us = time_t'({$urandom, $urandom});
        end
        period = pick_period();
        if ($urandom_range(29) == 0) begin
            clock_us = clock_us - time_t'($urandom_range(period));
        end
        knocks = $urandom_range(5, 1);
        t = clock_us + time_t'($urandom_range(3 * period + 1));
        for (int k = 0; k < knocks; k++) begin
            if (k > 0) begin
                if ($urandom_range(7) == 0) begin
                    t = t + time_t'($urandom_range(3 * period + 1));
                end else if ($urandom_range(1) == 0) begin
                    t = t + time_t'(period);
                end else begin
                    jit = period / 20;
                    t = t + time_t'(period - jit + $urandom_range(2 * jit));
                end
            end
            send_req(REQ_PULSE, t, 1'b0);
            // Contact bounce, a wrong-axis pulse or a plain tick.
            case ($urandom_range(5))
                0: send_req(REQ_PULSE, t + time_t'($urandom_range(32'(debounce_cfg))), 1'b0);
                1: send_req(REQ_PULSE, t + time_t'($urandom_range(period / 2)), 1'b1);
                2: send_req(REQ_TICK, t + time_t'($urandom_range(period / 2)),
                            1'($urandom_range(1)));
                default: ;
            endcase
        end
        // Let time run up to and past the quiet deadline.
        case ($urandom_range(4))
            0: begin
                send_req(REQ_TICK, t + time_t'(quiet_cfg) - 48'd1, 1'($urandom_range(1)));
                send_req(REQ_TICK, t + time_t'(quiet_cfg), 1'($urandom_range(1)));
            end
            1: send_req(REQ_TICK, t + time_t'(quiet_cfg) + time_t'($urandom_range(period)),
                        1'($urandom_range(1)));
            2: send_req(REQ_PULSE, t + time_t'(quiet_cfg) + time_t'($urandom_range(period)),
                        1'($urandom_range(1)));
            default: ;
        endcase
        clock_us = t + time_t'(quiet_cfg) + time_t'(period);
    endtask

    // Straight out of reset detection is off: pulses and ticks are not classified.
    task automatic test_disabled_after_reset();
        send_req(REQ_PULSE, '0, 1'b0);
        send_req(REQ_TICK, 48'd1000, 1'b1);
        send_req(REQ_PULSE, 48'd2000, 1'b1);
        drain_results();
    endtask

    // Default spacing bounds: debounce, wrong axis, arming, expiry, restart,
    // reset of the rhythm, cancel, saturation and time running backwards.
    task automatic test_default_rhythm();
        write_reg(CFG_DETECT_ENABLE, CFG_BITS'(1));
        send_req(REQ_PULSE, 48'd10, 1'b0);
        send_req(REQ_PULSE, 48'd100000, 1'b1);
        send_req(REQ_PULSE, 48'd200000, 1'b0);
        send_req(REQ_PULSE, 48'd700000, 1'b0);
        send_req(REQ_PULSE, 48'd710000, 1'b0);
        send_req(REQ_PULSE, 48'd1200000, 1'b0);
        send_req(REQ_TICK, 48'd2199999, 1'b0);
        send_req(REQ_TICK, 48'd2200000, 1'b1);
        // Too late for the window: the rhythm starts over.
        send_req(REQ_PULSE, 48'd2700000, 1'b0);
        send_req(REQ_PULSE, 48'd3200000, 1'b0);
        send_req(REQ_PULSE, 48'd3400000, 1'b0);
        send_req(REQ_PULSE, 48'd3900000, 1'b0);
        // Off the window but within the default bounds: taken as a new second knock.
        send_req(REQ_PULSE, 48'd4600000, 1'b0);
        send_req(REQ_PULSE, 48'd5300000, 1'b0);
        send_req(REQ_PULSE, 48'd6000000, 1'b0);
        send_req(REQ_PULSE, 48'd6700000, 1'b0);
        send_req(REQ_TICK, 48'd8000000, 1'b0);
        // Earlier than the last pulse, then earlier than the last knock.
        send_req(REQ_PULSE, 48'd6500000, 1'b0);
        send_req(REQ_PULSE, 48'd6600000, 1'b0);
        drain_results();
    endtask

    // Arm near the top of the time range so the deadline saturates, then let
    // it expire while detection is off.
    task automatic test_deadline_saturation();
        time_t t0;
        t0 = TIME_MAX - 48'd1000010;
        write_reg(CFG_QUIET, CFG_MAX_VAL);
        send_req(REQ_PULSE, t0, 1'b0);
        send_req(REQ_PULSE, t0 + 48'd500000, 1'b0);
        send_req(REQ_PULSE, t0 + 48'd1000000, 1'b0);
        drain_results();
        write_reg(CFG_DETECT_ENABLE, '0);
        send_req(REQ_TICK, TIME_MAX - 48'd1, 1'b0);
        send_req(REQ_TICK, TIME_MAX, 1'b0);
        send_req(REQ_PULSE, TIME_MAX, 1'b0);
        drain_results();
        clock_us = TIME_MAX;
    endtask

    // Random knock sequences under a series of register settings.
    task automatic test_random_rhythms();
        int unsigned target;
        int unsigned phase_start;
        target = sent_count + RANDOM_ITEMS;
        for (int phase = 0; sent_count < target; phase++) begin
            drain_results();
            case (phase % 7)
                0: set_config(CFG_BITS'(1), DEBOUNCE_RST, MIN_SEP_RST, MAX_SEP_RST, QUIET_RST);
                1: begin
                    set_config(rand_cfg(0, CFG_MAX_U) | CFG_BITS'(1), rand_cfg(0, 20),
                               rand_cfg(50, 200), rand_cfg(200, 600), rand_cfg(1, 1000));
                end
                2: set_config(CFG_BITS'(1), '0, '0, CFG_MAX_VAL, '0);
                3: set_config(CFG_BITS'(1), CFG_MAX_VAL, CFG_MAX_VAL, CFG_MAX_VAL, CFG_MAX_VAL);
                4: begin
                    // Lower bound above the upper bound.
                    set_config(CFG_BITS'(1), rand_cfg(0, 100), rand_cfg(2000, 5000),
                               rand_cfg(500, 1999), rand_cfg(0, CFG_MAX_U));
                end
                5: begin
                    set_config(rand_cfg(0, CFG_MAX_U), rand_cfg(0, CFG_MAX_U),
                               rand_cfg(0, CFG_MAX_U), rand_cfg(0, CFG_MAX_U),
                               rand_cfg(0, CFG_MAX_U));
                end
                default: begin
                    set_config(CFG_BITS'(1), rand_cfg(0, 5000), rand_cfg(10000, 40000),
                               rand_cfg(40000, 90000), rand_cfg(0, 200000));
                    // A write to an unused index must leave every register alone.
                    write_reg(CFG_UNUSED, rand_cfg(0, CFG_MAX_U));
                end
            endcase
            phase_start = sent_count;
            for (int seq = 0; sent_count < phase_start + PHASE_ITEMS && sent_count < target;
                    seq++) begin
                if (seq == 8 && phase == 0) hold_off_req = 1'b1;
                if (seq == 8 && phase == 1) drain_results();
                play_rhythm();
            end
        end
    endtask

    // Result side: random stalls, calm stretches and one long hold-off on request.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && !calm && $urandom_range(3) == 0) begin
                stall_left = pick_idle();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each result taken with the oldest prediction.
    always @(posedge aclk) begin : result_check
        krd_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_rsp_q.size() == 0) begin
                $display("%0t: result with none expected: trigger=%0d class=%0d count=%0d",
                         $time, m_data.trigger, m_data.pulse_class, m_data.knock_count);
                mismatch_count++;
            end else begin
                want = predicted_rsp_q.pop_front();
                compare_field("trigger", 3'(want.trigger), 3'(m_data.trigger));
                compare_field("pulse_class", 3'(want.pulse_class), 3'(m_data.pulse_class));
                compare_field("knock_count", want.knock_count, m_data.knock_count);
            end
        end
    end

    initial begin : test_sequence
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_disabled_after_reset();
        test_default_rhythm();
        test_deadline_saturation();
        test_random_rhythms();
        drain_results();
        if (mismatch_count == 0) begin
            $display("PASS knock_rhythm_detector_top");
        end else begin
            $display("FAIL knock_rhythm_detector_top");
        end
        $finish;
    end

    initial begin : watchdog
        #(4_000_000);
        $display("FAIL knock_rhythm_detector_top");
        $finish;
    end

endmodule
